// ===== rtl/sida_pkg.sv =====
// shared types and constants for the signed integer to decimal text block
// no dependencies
package sida_pkg;

   localparam int NUM_WIDTH   = 32;
   localparam int CHAR_WIDTH  = 7;
   localparam int MAX_DIGITS  = 10;
   localparam int DIGIT_WIDTH = 4;
   localparam int CNT_WIDTH   = $clog2(MAX_DIGITS + 1);

   localparam logic [CHAR_WIDTH-1:0] DIGIT_BASE = 7'd48;
   localparam logic [CHAR_WIDTH-1:0] DIGIT_TOP  = 7'd57;
   localparam logic [CHAR_WIDTH-1:0] MINUS_CHAR = 7'd45;

   // floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for every 32-bit x
   localparam logic [NUM_WIDTH-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int                   RECIP_SHIFT = 35;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SIGN,
      ST_DIGITS
   } state_type;

   typedef struct packed {
      logic load;
      logic divide;
      logic emit_sign;
      logic emit_digit;
   } cmd_type;

   typedef struct packed {
      logic quot_zero;
      logic neg;
      logic last_digit;
   } status_type;

endpackage

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// top level: signed 32-bit integer to decimal ascii text, one character per word
// depends on sida_pkg, sida_ctrl, sida_datapath
//
//   channel   direction   payload                            handshake
//   req       in          req_number[31:0] signed            req_valid / req_ready
//   rsp       out         rsp_text_char[6:0], rsp_last_char  rsp_valid / rsp_ready
//
// one number with d decimal digits takes a load step, d divide steps, a sign step if
// negative and d digit steps; rsp_ready low on a full output slot stalls the output;
// the divide-by-ten step (one reciprocal multiply a cycle) produces one digit per cycle;
// the output register then sends one character per cycle unless stalled, least digit last
// req_ready is high only while idle; the next number may enter while the final
// character still waits in the output register
// synchronous active-high reset clears the controller and the output valid
module signed_int_to_decimal_ascii
   import sida_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic signed [NUM_WIDTH-1:0] req_number,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CHAR_WIDTH-1:0] rsp_text_char,
   output logic                  rsp_last_char
);

   cmd_type    cmd;
   status_type status;

   sida_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sida_datapath u_datapath (
      .clock     (clock),
      .number    (req_number),
      .cmd       (cmd),
      .status    (status),
      .text_char (rsp_text_char),
      .last_char (rsp_last_char)
   );

`ifndef SYNTHESIS
   // controller is busy right after taking a number
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req_ready high the cycle after an accepted word");

   // only a minus sign or a digit leaves the block
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_text_char == MINUS_CHAR) ||
                     ((rsp_text_char >= DIGIT_BASE) && (rsp_text_char <= DIGIT_TOP))))
      else $error("rsp_text_char is not a minus sign or a digit");

   // the minus sign is never the final character
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_text_char == MINUS_CHAR)) |-> !rsp_last_char)
      else $error("minus sign flagged as last character");
`endif

endmodule

// ===== rtl/sida_datapath.sv =====
// datapath: magnitude register, divide-by-ten step, digit store, output word register
// depends on sida_pkg
module sida_datapath
   import sida_pkg::*;
(
   input  logic                  clock,
   input  logic [NUM_WIDTH-1:0]  number,
   input  cmd_type               cmd,
   output status_type            status,
   output logic [CHAR_WIDTH-1:0] text_char,
   output logic                  last_char
);

   logic [NUM_WIDTH-1:0]   mag_ff, mag_in;
   logic                   neg_ff, neg_in;
   logic [CNT_WIDTH-1:0]   ndig_ff, ndig_in;
   logic [DIGIT_WIDTH-1:0] digits_ff [MAX_DIGITS];
   logic [CHAR_WIDTH-1:0]  text_ff, text_in;
   logic                   last_ff, last_in;

   logic [2*NUM_WIDTH-1:0] prod;
   logic [NUM_WIDTH-1:0]   quot;
   logic [NUM_WIDTH-1:0]   quot_ten;
   logic [NUM_WIDTH-1:0]   rem_full;
   logic [DIGIT_WIDTH-1:0] rem;
   logic [CNT_WIDTH-1:0]   rd_idx;

   always_comb begin
      prod     = {{NUM_WIDTH{1'b0}}, mag_ff} * {{NUM_WIDTH{1'b0}}, RECIP_TEN};
      quot     = {{RECIP_SHIFT-NUM_WIDTH{1'b0}}, prod[2*NUM_WIDTH-1:RECIP_SHIFT]};
      quot_ten = (quot << 3) + (quot << 1);
      rem_full = mag_ff - quot_ten;
      rem      = rem_full[DIGIT_WIDTH-1:0];
      rd_idx   = ndig_ff - CNT_WIDTH'(1);
   end

   always_comb begin
      mag_in  = mag_ff;
      neg_in  = neg_ff;
      ndig_in = ndig_ff;
      text_in = text_ff;
      last_in = last_ff;
      if (cmd.load) begin
         neg_in  = number[NUM_WIDTH-1];
         // unsigned magnitude, so the most negative value needs no special case
         mag_in  = number[NUM_WIDTH-1] ? (~number + NUM_WIDTH'(1)) : number;
         ndig_in = '0;
      end
      if (cmd.divide) begin
         mag_in  = quot;
         ndig_in = ndig_ff + CNT_WIDTH'(1);
      end
      if (cmd.emit_sign) begin
         text_in = MINUS_CHAR;
         last_in = 1'b0;
      end
      if (cmd.emit_digit) begin
         text_in = DIGIT_BASE + CHAR_WIDTH'(digits_ff[rd_idx]);
         last_in = (ndig_ff == CNT_WIDTH'(1));
         ndig_in = rd_idx;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      ndig_ff <= ndig_in;
      text_ff <= text_in;
      last_ff <= last_in;
      if (cmd.divide) begin
         digits_ff[ndig_ff] <= rem;
      end
   end

   assign status.quot_zero  = (quot == '0);
   assign status.neg        = neg_ff;
   assign status.last_digit = (ndig_ff == CNT_WIDTH'(1));
   assign text_char         = text_ff;
   assign last_char         = last_ff;

endmodule

// ===== rtl/sida_ctrl.sv =====
// controller: sequences load, divide steps and character output, owns the output valid
// depends on sida_pkg
module sida_ctrl
   import sida_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cmd.divide = 1'b1;
            if (status.quot_zero) begin
               state_in = status.neg ? ST_SIGN : ST_DIGITS;
            end
         end
         ST_SIGN: begin
            if (slot_free) begin
               cmd.emit_sign = 1'b1;
               state_in      = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (slot_free) begin
               cmd.emit_digit = 1'b1;
               if (status.last_digit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (cmd.emit_sign || cmd.emit_digit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
